>>> rtl/assert_macros.svh
// Assertion helpers used by the RTL controller, hra_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_HOLDS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_HOLDS(lbl, clk, rst, prop)

`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> rtl/hra_pkg.sv
package hra_pkg;

  localparam int KEY_SLOTS_DEF = 6;
  localparam int REPORT_SLOTS  = 6;

  localparam logic [3:0] K_KEY_PRESS   = 4'd0;
  localparam logic [3:0] K_KEY_RELEASE = 4'd1;
  localparam logic [3:0] K_MOD_PRESS   = 4'd2;
  localparam logic [3:0] K_MOD_RELEASE = 4'd3;
  localparam logic [3:0] K_MOVE        = 4'd4;
  localparam logic [3:0] K_BTN_PRESS   = 4'd5;
  localparam logic [3:0] K_BTN_RELEASE = 4'd6;
  localparam logic [3:0] K_RELEASE_ALL = 4'd7;
  localparam logic [3:0] K_CONNECT     = 4'd8;
  localparam logic [3:0] K_DISCONNECT  = 4'd9;

  localparam logic [1:0] RID_KB = 2'd1;
  localparam logic [1:0] RID_MS = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_KB,
    S_MS
  } state_t;

  typedef struct packed {
    logic load;
    logic show_ms;
  } ctl_cmd_t;

  typedef struct packed {
    logic link_up;
    logic notify;
  } dp_status_t;

endpackage

>>> rtl/hra_ctrl.sv
`include "assert_macros.svh"

module hra_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [3:0]          kind,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                last,
  output hra_pkg::ctl_cmd_t   cmd,
  input  hra_pkg::dp_status_t status
);
  import hra_pkg::*;

  state_t state, state_next;
  logic   two, two_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      two   <= 1'b0;
    end else begin
      state <= state_next;
      two   <= two_next;
    end
  end

  always_comb begin
    state_next  = state;
    two_next    = two;
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    last        = 1'b0;
    cmd.load    = 1'b0;
    cmd.show_ms = 1'b0;
    accept      = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
        cmd.load = in_valid;
        if (in_valid) begin
          two_next = 1'b0;
          if (kind inside {K_KEY_PRESS, K_KEY_RELEASE, K_MOD_PRESS, K_MOD_RELEASE}) begin
            if (status.link_up) state_next = S_KB;
          end else if (kind inside {K_MOVE, K_BTN_PRESS, K_BTN_RELEASE}) begin
            if (status.link_up && status.notify) state_next = S_MS;
          end else if (kind == K_RELEASE_ALL) begin
            if (status.link_up) begin
              state_next = S_KB;
              two_next   = status.notify;
            end
          end
        end
      end
      S_KB: begin
        out_valid = 1'b1;
        last      = !two;
        if (!out_stall) state_next = two ? S_MS : S_IDLE;
      end
      S_MS: begin
        out_valid   = 1'b1;
        last        = 1'b1;
        cmd.show_ms = 1'b1;
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  `ASSERT_HOLDS(a_no_accept_busy, clk, rst, !(out_valid && !in_stall))
  `ASSERT_HOLDS(a_ms_last, clk, rst, !(state == S_MS) || last)
  `ASSERT_NEXT(a_link_silent, clk, rst,
               accept && (kind == K_CONNECT || kind == K_DISCONNECT), !out_valid)
  `ASSERT_NEXT(a_pair_order, clk, rst,
               (state == S_KB) && two && !out_stall, (state == S_MS) && last)

endmodule

>>> rtl/hra_datapath.sv
module hra_datapath #(
  parameter int KEY_SLOTS = hra_pkg::KEY_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  hra_pkg::ctl_cmd_t   cmd,
  output hra_pkg::dp_status_t status,
  input  logic [3:0]          kind,
  input  logic [7:0]          key_code,
  input  logic [7:0]          mod_mask,
  input  logic signed [7:0]   move_dx,
  input  logic signed [7:0]   move_dy,
  input  logic signed [7:0]   move_wheel,
  input  logic [7:0]          button_mask,
  input  logic                cfg_write,
  input  logic                cfg_data,
  output logic [1:0]          report_id,
  output logic [7:0]          report_modifiers,
  output logic [47:0]         report_keys,
  output logic [7:0]          report_buttons,
  output logic signed [7:0]   report_dx,
  output logic signed [7:0]   report_dy,
  output logic signed [7:0]   report_wheel
);
  import hra_pkg::*;

  localparam int IW    = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int NSHOW = (KEY_SLOTS < REPORT_SLOTS) ? KEY_SLOTS : REPORT_SLOTS;

  logic [7:0]        slots [KEY_SLOTS];
  logic [7:0]        modifiers;
  logic              link_up;
  logic              notify;
  logic [7:0]        ms_buttons;
  logic signed [7:0] ms_dx, ms_dy, ms_wheel;

  logic              held, has_free;
  logic [IW-1:0]     free_idx;
  logic [47:0]       packed_keys;

  always_comb begin
    held     = 1'b0;
    has_free = 1'b0;
    free_idx = '0;
    for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
      if (slots[i] == key_code) held = 1'b1;
      if (slots[i] == 8'h00) begin
        has_free = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_SLOTS; i++) slots[i] <= 8'h00;
      modifiers <= 8'h00;
      link_up   <= 1'b0;
      notify    <= 1'b1;
    end else begin
      if (cfg_write) notify <= cfg_data;
      if (cmd.load) begin
        case (kind)
          K_KEY_PRESS: begin
            if (key_code != 8'h00 && !held && has_free) slots[free_idx] <= key_code;
          end
          K_KEY_RELEASE: begin
            for (int i = 0; i < KEY_SLOTS; i++)
              if (slots[i] == key_code) slots[i] <= 8'h00;
          end
          K_MOD_PRESS:   modifiers <= modifiers | mod_mask;
          K_MOD_RELEASE: modifiers <= modifiers & ~mod_mask;
          K_RELEASE_ALL: begin
            for (int i = 0; i < KEY_SLOTS; i++) slots[i] <= 8'h00;
            modifiers <= 8'h00;
          end
          K_CONNECT: link_up <= 1'b1;
          K_DISCONNECT: begin
            link_up <= 1'b0;
            for (int i = 0; i < KEY_SLOTS; i++) slots[i] <= 8'h00;
            modifiers <= 8'h00;
          end
          default: ;
        endcase
      end
    end
  end

  // one-shot mouse payload, captured per item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ms_buttons <= (kind == K_BTN_PRESS) ? button_mask : 8'h00;
      ms_dx      <= (kind == K_MOVE) ? move_dx : 8'sh00;
      ms_dy      <= (kind == K_MOVE) ? move_dy : 8'sh00;
      ms_wheel   <= (kind == K_MOVE) ? move_wheel : 8'sh00;
    end
  end

  always_comb begin
    packed_keys = '0;
    for (int i = 0; i < NSHOW; i++) packed_keys[8*i +: 8] = slots[i];
  end

  assign status.link_up = link_up;
  assign status.notify  = notify;

  always_comb begin
    if (cmd.show_ms) begin
      report_id        = RID_MS;
      report_modifiers = 8'h00;
      report_keys      = '0;
      report_buttons   = ms_buttons;
      report_dx        = ms_dx;
      report_dy        = ms_dy;
      report_wheel     = ms_wheel;
    end else begin
      report_id        = RID_KB;
      report_modifiers = modifiers;
      report_keys      = packed_keys;
      report_buttons   = 8'h00;
      report_dx        = 8'sh00;
      report_dy        = 8'sh00;
      report_wheel     = 8'sh00;
    end
  end

endmodule

>>> rtl/hid_report_assembler_unit.sv
// An item is taken while the controller is idle; its first report is valid the next cycle.
// Throughput: one item every cycle when it makes no report; else the controller
// holds input while the item's N reports (N up to 2) drain.
// Reset (rst, synchronous, active high): key slots and modifiers cleared,
// link down, mouse notify set, no report pending.
module hid_report_assembler_unit #(
  parameter int KEY_SLOTS = hra_pkg::KEY_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [3:0]        kind,
  input  logic [7:0]        key_code,
  input  logic [7:0]        mod_mask,
  input  logic signed [7:0] move_dx,
  input  logic signed [7:0] move_dy,
  input  logic signed [7:0] move_wheel,
  input  logic [7:0]        button_mask,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        report_id,
  output logic [7:0]        report_modifiers,
  output logic [47:0]       report_keys,
  output logic [7:0]        report_buttons,
  output logic signed [7:0] report_dx,
  output logic signed [7:0] report_dy,
  output logic signed [7:0] report_wheel,
  output logic              last
);
  import hra_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  hra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .last      (last),
    .cmd       (cmd),
    .status    (status)
  );

  hra_datapath #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .kind             (kind),
    .key_code         (key_code),
    .mod_mask         (mod_mask),
    .move_dx          (move_dx),
    .move_dy          (move_dy),
    .move_wheel       (move_wheel),
    .button_mask      (button_mask),
    .cfg_write        (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .report_id        (report_id),
    .report_modifiers (report_modifiers),
    .report_keys      (report_keys),
    .report_buttons   (report_buttons),
    .report_dx        (report_dx),
    .report_dy        (report_dy),
    .report_wheel     (report_wheel)
  );

endmodule

>>> test/hid_report_checker.sv
module hid_report_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [3:0]  kind,
  input  logic [7:0]  key_code,
  input  logic [7:0]  mod_mask,
  input  logic [7:0]  move_dx,
  input  logic [7:0]  move_dy,
  input  logic [7:0]  move_wheel,
  input  logic [7:0]  button_mask,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  report_id,
  input  logic [7:0]  report_modifiers,
  input  logic [47:0] report_keys,
  input  logic [7:0]  report_buttons,
  input  logic [7:0]  report_dx,
  input  logic [7:0]  report_dy,
  input  logic [7:0]  report_wheel,
  input  logic        last,
  output int          errors,
  output int          pending,
  output int          compared
);
  timeunit 1ns;
  timeprecision 1ps;
  import hra_pkg::*;

  localparam int SLOTS = KEY_SLOTS_DEF;

  typedef struct packed {
    logic [1:0]  id;
    logic [7:0]  mods;
    logic [47:0] keys;
    logic [7:0]  buttons;
    logic [7:0]  dx;
    logic [7:0]  dy;
    logic [7:0]  wheel;
    logic        last;
  } hid_report_t;

  logic [7:0]  held_keys [SLOTS];
  logic [7:0]  mod_bits;
  logic        link_up;
  logic        notify_on;
  hid_report_t want_reports [$];

  task automatic flag(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [47:0] got, input logic [47:0] want);
    if (got !== want) flag($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic clear_keyboard();
    for (int i = 0; i < SLOTS; i++) held_keys[i] = 8'h00;
    mod_bits = 8'h00;
  endtask

  function automatic hid_report_t kb_report();
    hid_report_t r;
    r = '0;
    r.id = RID_KB;
    r.mods = mod_bits;
    for (int i = 0; i < SLOTS && i < REPORT_SLOTS; i++) r.keys[8*i +: 8] = held_keys[i];
    return r;
  endfunction

  function automatic hid_report_t ms_report(input logic [7:0] btn, input logic [7:0] dx,
                                            input logic [7:0] dy, input logic [7:0] wh);
    hid_report_t r;
    r = '0;
    r.id = RID_MS;
    r.buttons = btn;
    r.dx = dx;
    r.dy = dy;
    r.wheel = wh;
    return r;
  endfunction

  task automatic predict_reports();
    hid_report_t made [2];
    int n;
    logic found;
    logic placed;
    logic ms_ok;
    n = 0;
    found = 1'b0;
    placed = 1'b0;
    ms_ok = link_up && notify_on;
    case (kind)
      K_KEY_PRESS: begin
        if (key_code != 8'h00) begin
          for (int i = 0; i < SLOTS; i++) if (held_keys[i] == key_code) found = 1'b1;
          if (!found) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (!placed && held_keys[i] == 8'h00) begin
                held_keys[i] = key_code;
                placed = 1'b1;
              end
            end
          end
        end
      end
      K_KEY_RELEASE: begin
        for (int i = 0; i < SLOTS; i++) if (held_keys[i] == key_code) held_keys[i] = 8'h00;
      end
      K_MOD_PRESS: mod_bits = mod_bits | mod_mask;
      K_MOD_RELEASE: mod_bits = mod_bits & ~mod_mask;
      K_MOVE: begin
        if (ms_ok) begin
          made[0] = ms_report(8'h00, move_dx, move_dy, move_wheel);
          n = 1;
        end
      end
      K_BTN_PRESS: begin
        if (ms_ok) begin
          made[0] = ms_report(button_mask, 8'h00, 8'h00, 8'h00);
          n = 1;
        end
      end
      K_BTN_RELEASE: begin
        if (ms_ok) begin
          made[0] = ms_report(8'h00, 8'h00, 8'h00, 8'h00);
          n = 1;
        end
      end
      K_RELEASE_ALL: begin
        clear_keyboard();
        if (link_up) begin
          made[0] = kb_report();
          n = 1;
          if (notify_on) begin
            made[1] = ms_report(8'h00, 8'h00, 8'h00, 8'h00);
            n = 2;
          end
        end
      end
      K_CONNECT: link_up = 1'b1;
      K_DISCONNECT: begin
        link_up = 1'b0;
        clear_keyboard();
      end
      default: ;
    endcase
    if (kind <= K_MOD_RELEASE && link_up) begin
      made[0] = kb_report();
      n = 1;
    end
    if (n > 0) made[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) want_reports.push_back(made[i]);
  endtask

  task automatic check_report();
    hid_report_t got;
    hid_report_t want;
    got = {report_id, report_modifiers, report_keys, report_buttons,
           report_dx, report_dy, report_wheel, last};
    if (want_reports.size() == 0) begin
      flag($sformatf("report id %0h with no item waiting", report_id));
    end else begin
      want = want_reports.pop_front();
      compared++;
      check_field("report_id", got.id, want.id);
      check_field("report_modifiers", got.mods, want.mods);
      check_field("report_keys", got.keys, want.keys);
      check_field("report_buttons", got.buttons, want.buttons);
      check_field("report_dx", got.dx, want.dx);
      check_field("report_dy", got.dy, want.dy);
      check_field("report_wheel", got.wheel, want.wheel);
      check_field("last", got.last, want.last);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_keyboard();
      link_up = 1'b0;
      notify_on = 1'b1;
      want_reports.delete();
      errors = 0;
      compared = 0;
    end else begin
      if (out_valid && !out_stall) check_report();
      if (cfg_valid && cfg_ready) notify_on = cfg_data;
      if (in_valid && !in_stall) predict_reports();
    end
    pending <= want_reports.size();
  end

endmodule

>>> test/hid_report_assembler_unit_test.sv
module hid_report_assembler_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hra_pkg::*;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] code;
    logic [7:0] mask;
    logic [7:0] dx;
    logic [7:0] dy;
    logic [7:0] wheel;
    logic [7:0] btn;
  } hid_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [3:0]  kind = '0;
  logic [7:0]  key_code = '0;
  logic [7:0]  mod_mask = '0;
  logic [7:0]  move_dx = '0;
  logic [7:0]  move_dy = '0;
  logic [7:0]  move_wheel = '0;
  logic [7:0]  button_mask = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_data = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        cfg_ready;
  logic        out_valid;
  logic [1:0]  report_id;
  logic [7:0]  report_modifiers;
  logic [47:0] report_keys;
  logic [7:0]  report_buttons;
  logic [7:0]  report_dx;
  logic [7:0]  report_dy;
  logic [7:0]  report_wheel;
  logic        last;

  int errors;
  int pending;
  int compared;
  int send_idle_pct = 15;
  int recv_idle_pct = 85;
  int items_sent = 0;

  always #5 clk = ~clk;

  hid_report_assembler_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .key_code(key_code), .mod_mask(mod_mask),
    .move_dx(move_dx), .move_dy(move_dy), .move_wheel(move_wheel),
    .button_mask(button_mask),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .report_id(report_id), .report_modifiers(report_modifiers),
    .report_keys(report_keys), .report_buttons(report_buttons),
    .report_dx(report_dx), .report_dy(report_dy), .report_wheel(report_wheel),
    .last(last)
  );

  hid_report_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .key_code(key_code), .mod_mask(mod_mask),
    .move_dx(move_dx), .move_dy(move_dy), .move_wheel(move_wheel),
    .button_mask(button_mask),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .report_id(report_id), .report_modifiers(report_modifiers),
    .report_keys(report_keys), .report_buttons(report_buttons),
    .report_dx(report_dx), .report_dy(report_dy), .report_wheel(report_wheel),
    .last(last),
    .errors(errors), .pending(pending), .compared(compared)
  );

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic hid_item_t make_item(input logic [3:0] k, input logic [7:0] code,
                                          input logic [7:0] mask, input logic [7:0] dx,
                                          input logic [7:0] dy, input logic [7:0] wh,
                                          input logic [7:0] btn);
    hid_item_t it;
    it = {k, code, mask, dx, dy, wh, btn};
    return it;
  endfunction

  // small pool of codes so repeats, releases and full slots happen often
  function automatic logic [7:0] pick_code();
    int r;
    r = $urandom_range(99);
    if (r < 85) return 8'h04 + 8'($urandom_range(9));
    if (r < 93) return 8'h00;
    return 8'($urandom_range(255));
  endfunction

  function automatic hid_item_t rand_item();
    hid_item_t it;
    int r;
    it.kind = 4'($urandom_range(15));
    it.code = 8'($urandom_range(255));
    it.mask = 8'($urandom_range(255));
    it.dx = 8'($urandom_range(255));
    it.dy = 8'($urandom_range(255));
    it.wheel = 8'($urandom_range(255));
    it.btn = 8'($urandom_range(255));
    r = $urandom_range(99);
    if (r < 28) begin
      it.kind = K_KEY_PRESS;
      it.code = pick_code();
    end else if (r < 44) begin
      it.kind = K_KEY_RELEASE;
      it.code = pick_code();
    end else if (r < 52) begin
      it.kind = K_MOD_PRESS;
    end else if (r < 58) begin
      it.kind = K_MOD_RELEASE;
    end else if (r < 68) begin
      it.kind = K_MOVE;
    end else if (r < 76) begin
      it.kind = K_BTN_PRESS;
    end else if (r < 82) begin
      it.kind = K_BTN_RELEASE;
    end else if (r < 86) begin
      it.kind = K_RELEASE_ALL;
    end else if (r < 92) begin
      it.kind = K_CONNECT;
    end else if (r < 95) begin
      it.kind = K_DISCONNECT;
    end else if (it.kind <= K_DISCONNECT) begin
      it.kind = 4'($urandom_range(15, 10));
    end
    return it;
  endfunction

  task automatic send_item(input hid_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= it.kind;
    key_code <= it.code;
    mod_mask <= it.mask;
    move_dx <= it.dx;
    move_dy <= it.dy;
    move_wheel <= it.wheel;
    button_mask <= it.btn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_notify(input logic v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_notify(1'b1);
    // link down: state moves, nothing reported
    send_item(make_item(K_MOVE, 8'h00, 8'h00, 8'h80, 8'h7f, 8'hff, 8'h00));
    send_item(make_item(K_KEY_PRESS, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(K_CONNECT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(K_KEY_PRESS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(K_KEY_PRESS, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(K_KEY_PRESS, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(K_KEY_PRESS, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(K_KEY_PRESS, 8'h07, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(K_KEY_PRESS, 8'hfe, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(K_KEY_PRESS, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    // slots full
    send_item(make_item(K_KEY_PRESS, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(K_KEY_RELEASE, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(K_MOD_PRESS, 8'h00, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(K_MOD_RELEASE, 8'h00, 8'h0f, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(K_MOVE, 8'h00, 8'h00, 8'h80, 8'h7f, 8'hff, 8'h00));
    send_item(make_item(K_MOVE, 8'h00, 8'h00, 8'h7f, 8'h80, 8'h01, 8'h00));
    send_item(make_item(K_BTN_PRESS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff));
    send_item(make_item(K_BTN_RELEASE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff));
    send_item(make_item(K_RELEASE_ALL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(4'd10, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    send_item(make_item(4'd15, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    send_item(make_item(K_DISCONNECT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(K_RELEASE_ALL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(K_CONNECT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    wait_drained();

    // notify off: mouse silent, release all gives the keyboard report only
    write_notify(1'b0);
    send_item(make_item(K_MOVE, 8'h00, 8'h00, 8'h01, 8'h02, 8'h03, 8'h00));
    send_item(make_item(K_RELEASE_ALL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(K_KEY_PRESS, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 15 : (p == 1) ? 85 : 0;
      recv_idle_pct <= (p == 0) ? 85 : (p == 1) ? 15 : 0;
      for (int h = 0; h < 2; h++) begin
        wait_drained();
        write_notify(logic'((p + h) % 2));
        repeat (142) send_item(rand_item());
      end
    end
    wait_drained();
    repeat (8) @(posedge clk);

    $display("Sent %0d items under three idle profiles, mouse notify on and off", items_sent);
    $display("Compared %0d reports, %0d mismatches", compared, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout waiting for items or reports");
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> hid_report_assembler_unit.f
+incdir+rtl
rtl/hra_pkg.sv
rtl/hra_ctrl.sv
rtl/hra_datapath.sv
rtl/hid_report_assembler_unit.sv
test/hid_report_checker.sv
test/hid_report_assembler_unit_test.sv
